[rtl/adf_pkg.sv]
// Shared types, constants and the callsign normalization function for the
// acknowledgement duplicate filter table. No dependencies.
package adf_pkg;

  // Field widths of one acknowledgement record.
  localparam int CALL_W     = 64;
  localparam int ID_W       = 32;
  localparam int CALL_BYTES = CALL_W / 8;

  // Number of callsign characters that take part in storage and comparison.
  localparam int CALLSIGN_CHARS = 8;

  // Default table depth handed to the top level.
  localparam int DEF_TABLE_ENTRIES = 32;

  // Operation codes carried by the func field.
  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_ADD   = 1'b1;

  // One stored record, also used as the search key.
  typedef struct packed {
    logic [CALL_W-1:0] source;
    logic [CALL_W-1:0] node;
    logic [ID_W-1:0]   id;
  } adf_key_t;

  localparam int KEY_W = $bits(adf_key_t);

  // Tag that travels with a table read so the compare stage knows whether
  // the entry has ever been written.
  typedef struct packed {
    logic issue;
    logic live;
  } adf_rd_tag_t;

  // Cut a packed callsign at its first zero byte and at CALLSIGN_CHARS bytes.
  function automatic logic [CALL_W-1:0] norm_call(input logic [CALL_W-1:0] v);
    logic [CALL_W-1:0] r;
    logic              keep;
    r    = '0;
    keep = 1'b1;
    for (int k = 0; k < CALL_BYTES; k++) begin
      if (k >= CALLSIGN_CHARS || v[8*k +: 8] == 8'd0) keep = 1'b0;
      if (keep) r[8*k +: 8] = v[8*k +: 8];
    end
    return r;
  endfunction

endpackage

[rtl/adf_entry_ram.sv]
// Record store of the duplicate filter: one write port and one read port,
// read data registered. Depends on adf_pkg for the record width.
module adf_entry_ram
  import adf_pkg::*;
#(
  parameter int DEPTH = DEF_TABLE_ENTRIES,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  adf_key_t      wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output adf_key_t      rdata
);

  adf_key_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/adf_key_match.sv]
// Compare stage of the table scan: lines up each read tag with the RAM data
// and accumulates the hit flag. Depends on adf_pkg.
module adf_key_match
  import adf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  adf_rd_tag_t tag,
  input  adf_key_t    key,
  input  adf_key_t    rdata,
  output logic        hit
);

  adf_rd_tag_t tag_r;
  logic        hit_r;
  logic        entry_eq;

  // An entry never written is treated as all zeros; the RAM itself has no reset.
  assign entry_eq = tag_r.live ? (rdata == key) : (key == '0);

  // Delay the tag by the RAM read latency.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag;
    end
  end

  // Sticky hit flag for the current transaction.
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hit_r <= 1'b0;
    end else if (tag_r.issue && entry_eq) begin
      hit_r <= 1'b1;
    end
  end

  assign hit = hit_r;

endmodule

[rtl/ack_duplicate_filter_table.sv]
// Acknowledgement duplicate filter table, top level.
// Each transaction is scanned in ST_SCAN, drained in ST_DRAIN and delivered from
// ST_DONE once the output register is free; a new one waits until then.
// The scan reads the record RAM (one write, one read port) one entry per cycle.
// Reset: control state, write pointer and fill flag clear at once; no clearing
// pass, unwritten entries read as zero through the fill tracking.
module ack_duplicate_filter_table
  import adf_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [CALL_W-1:0] in_source_call,
  input  logic [CALL_W-1:0] in_node_call,
  input  logic [ID_W-1:0]   in_message_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  adf_key_t      key_r;
  logic          add_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] wp_r;
  logic          full_r;
  logic          out_valid_r;
  logic          out_found_r;

  logic          in_fire;
  logic          out_free;
  logic          finish;
  logic          do_write;
  logic          hit;
  adf_rd_tag_t   rd_tag;
  adf_key_t      rdata;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign finish   = (state_r == ST_DONE) && out_free;
  assign do_write = finish && (add_r == FUNC_ADD) && !hit;

  // Read tag for the entry being fetched this cycle.
  assign rd_tag.issue = (state_r == ST_SCAN);
  assign rd_tag.live  = full_r || (rd_addr_r < wp_r);

  // Sequencer: scan every entry, let the last read land, then deliver.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_SCAN;
      ST_SCAN:  if (rd_addr_r == LAST_ADDR) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_addr_r <= '0;
      wp_r      <= '0;
      full_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        rd_addr_r <= '0;
      end else if (state_r == ST_SCAN) begin
        rd_addr_r <= rd_addr_r + AW'(1);
      end
      if (do_write) begin
        if (wp_r == LAST_ADDR) begin
          wp_r   <= '0;
          full_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
    end
  end

  // Normalized key and operation of the transaction in flight.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r.source <= norm_call(in_source_call);
      key_r.node   <= norm_call(in_node_call);
      key_r.id     <= in_message_id;
      add_r        <= in_func;
    end
  end

  // Output register; it frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_found_r <= hit;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  adf_entry_ram #(
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (wp_r),
    .wdata (key_r),
    .re    (rd_tag.issue),
    .raddr (rd_addr_r),
    .rdata (rdata)
  );

  adf_key_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (in_fire),
    .tag   (rd_tag),
    .key   (key_r),
    .rdata (rdata),
    .hit   (hit)
  );

endmodule

[rtl/adf_checker.sv]
// Port-level checker for the acknowledgement duplicate filter table and the
// bind that attaches it to the top level. Depends on adf_pkg.
module adf_checker
  import adf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_func,
  input logic [CALL_W-1:0] in_source_call,
  input logic [CALL_W-1:0] in_node_call,
  input logic [ID_W-1:0]   in_message_id,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found
);

  // One transaction at a time: the input closes right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a lookup is in progress");

  // A result cannot appear in the cycle after its transaction was taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared before the table scan could finish");

  // A waiting input transaction keeps its payload until it is taken.
  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid &&
      $stable({in_func, in_source_call, in_node_call, in_message_id}))
    else $error("waiting input transaction changed or dropped");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending and the input open.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

endmodule

bind ack_duplicate_filter_table adf_checker u_adf_checker (.*);
